>>> rtl/core/gwwl_pkg.sv
package gwwl_pkg;

  // sizing
  localparam int WORD_MAX   = 32;
  localparam int COORD_BITS = 16;
  localparam int XW         = COORD_BITS + 10;
  localparam int LW         = $clog2(WORD_MAX + 1);
  localparam int AW         = $clog2(WORD_MAX);
  localparam int OUT_BITS   = 16;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 15;

  localparam logic [CFG_IDX_W-1:0] CFG_PAD_LEFT     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAD_RIGHT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAD_TOP      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BOUND_WIDTH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BOUND_HEIGHT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_SPACE   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_ASCENDER     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_DESCENDER    = 3'd7;

  // character codes
  localparam logic [7:0] CH_END     = 8'd0;
  localparam logic [7:0] CH_NEWLINE = 8'd10;
  localparam logic [7:0] CH_SPACE   = 8'd32;

  // result codes
  localparam logic       KIND_LETTER = 1'b0;
  localparam logic       KIND_SIZE   = 1'b1;
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_HEIGHT   = 2'd1;
  localparam logic [1:0] ST_TRUNC    = 2'd2;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [XW-1:0]         xw_t;

  localparam xw_t C_HI = xw_t'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
  localparam xw_t C_LO = -C_HI - xw_t'(1);
  localparam xw_t O_HI = xw_t'(32767);
  localparam xw_t O_LO = xw_t'(-32768);

  typedef struct packed {
    logic [7:0]        char_code;
    logic [7:0]        glyph_advance;
    logic signed [7:0] bearing_y;
    logic signed [7:0] kern_next;
  } in_item_t;

  typedef struct packed {
    logic                       kind;
    logic [15:0]                char_index;
    logic signed [OUT_BITS-1:0] x_pos;
    logic signed [OUT_BITS-1:0] y_pos;
    logic [1:0]                 status;
    logic                       last;
  } out_item_t;

  // one buffered letter of the current word
  typedef struct packed {
    logic [7:0]        adv;
    logic signed [7:0] bear;
    logic signed [7:0] kern;
  } word_ent_t;

  localparam int WORD_W = $bits(word_ent_t);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_EMIT,
    S_FIN
  } state_e;

  // clamp to the signed coordinate range
  function automatic coord_t sat_c(xw_t v);
    xw_t r;
    r = (v > C_HI) ? C_HI : ((v < C_LO) ? C_LO : v);
    return coord_t'(r);
  endfunction

  // clamp a coordinate to the output field range
  function automatic logic signed [OUT_BITS-1:0] sat_o(coord_t c);
    xw_t v;
    xw_t r;
    v = xw_t'(c);
    r = (v > O_HI) ? O_HI : ((v < O_LO) ? O_LO : v);
    return r[OUT_BITS-1:0];
  endfunction

endpackage

>>> rtl/core/gwwl_ram.sv
module gwwl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read, holds while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/greedy_word_wrap_layout_unit.sv
// Greedy word-wrap layout: one character per input transaction. A letter is accepted, then
// goes through the wrap test and a write to the word RAM; a letter arriving with the word
// buffer full yields one result marked truncated. For a space, newline or end code the
// word RAM is read once per buffered letter and one letter position leaves per cycle while
// the output side takes them, so the word RAM read port sets the flush rate. The end code
// adds one size result and returns the text state to its start values; the pen is loaded
// from the padding and ascender registers at the first character of each text. Input stall
// is high from acceptance until that character is done.
module greedy_word_wrap_layout_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  gwwl_pkg::in_item_t                   in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output gwwl_pkg::out_item_t                  out_data_o,
  input  logic                                 cfg_we_i,
  input  logic [gwwl_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [gwwl_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  import gwwl_pkg::*;

  // configuration registers
  logic [11:0]        pad_left_q, pad_right_q, pad_top_q, line_space_q;
  logic [14:0]        bound_width_q, bound_height_q;
  logic signed [12:0] ascender_q, descender_q;

  // text state
  state_e         state_q, state_d;
  in_item_t       in_q;
  logic           open_q, open_d;
  coord_t         pen_x_q, pen_x_d;
  coord_t         pen_y_q, pen_y_d;
  coord_t         ww_q, ww_d;
  coord_t         mlw_q, mlw_d;
  logic [LW-1:0]  letters_q, letters_d;
  logic [LW-1:0]  idx_q, idx_d;
  logic [15:0]    pos_q, pos_d;
  logic [15:0]    first_pos_q, first_pos_d;
  xw_t            x_q, x_d;
  logic           out_valid_q, out_valid_d;
  out_item_t      out_q, out_d;

  // word RAM port signals
  logic           ram_we, ram_re;
  logic [AW-1:0]  ram_waddr, ram_raddr;
  word_ent_t      ram_wdata, ram_rdata;

  // datapath terms
  logic           accept, out_free, is_letter, word_full, wrap, size_over, more;
  logic [LW-1:0]  idx_nx;
  xw_t            sum_adv, max_w, ww_adv, pen_line, pen_ww, letter_x, letter_y, height_x;
  coord_t         left_pen, pen_end, size_w, size_h;

  gwwl_ram #(
    .WIDTH (WORD_W),
    .DEPTH (WORD_MAX)
  ) u_word_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // handshakes
  assign in_stall_o  = (state_q != S_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pad_left_q     <= '0;
      pad_right_q    <= '0;
      pad_top_q      <= '0;
      bound_width_q  <= '0;
      bound_height_q <= '0;
      line_space_q   <= 12'd16;
      ascender_q     <= 13'sd12;
      descender_q    <= -13'sd4;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PAD_LEFT:     pad_left_q     <= cfg_data_i[11:0];
        CFG_PAD_RIGHT:    pad_right_q    <= cfg_data_i[11:0];
        CFG_PAD_TOP:      pad_top_q      <= cfg_data_i[11:0];
        CFG_BOUND_WIDTH:  bound_width_q  <= cfg_data_i[14:0];
        CFG_BOUND_HEIGHT: bound_height_q <= cfg_data_i[14:0];
        CFG_LINE_SPACE:   line_space_q   <= cfg_data_i[11:0];
        CFG_ASCENDER:     ascender_q     <= cfg_data_i[12:0];
        CFG_DESCENDER:    descender_q    <= cfg_data_i[12:0];
        default: ;
      endcase
    end
  end

  // arithmetic shared by the states
  always_comb begin
    is_letter = !(in_q.char_code inside {CH_END, CH_NEWLINE, CH_SPACE});
    word_full = (letters_q >= LW'(WORD_MAX));
    sum_adv   = xw_t'(pen_x_q) + xw_t'(ww_q) + xw_t'(in_q.glyph_advance);
    max_w     = xw_t'(bound_width_q) - xw_t'(pad_right_q);
    wrap      = (bound_width_q != '0) && (sum_adv > max_w);
    ww_adv    = xw_t'(ww_q) + xw_t'(in_q.glyph_advance);
    pen_line  = xw_t'(pen_y_q) + xw_t'(line_space_q);
    left_pen  = sat_c(xw_t'(pad_left_q));
    pen_ww    = xw_t'(pen_x_q) + xw_t'(ww_q);
    pen_end   = sat_c(pen_ww);
    size_w    = (mlw_q > pen_end) ? mlw_q : pen_end;
    height_x  = xw_t'(pen_y_q) - xw_t'(descender_q);
    size_h    = sat_c(height_x);
    size_over = (bound_height_q != '0) && (xw_t'(size_h) > xw_t'(bound_height_q));
    letter_x  = x_q - xw_t'(ram_rdata.kern);
    letter_y  = xw_t'(pen_y_q) - xw_t'(ram_rdata.bear);
    idx_nx    = idx_q + LW'(1);
    more      = (idx_nx < letters_q);
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_EXEC;
      end
      S_EXEC: begin
        if (is_letter) begin
          if (!word_full || out_free) state_d = S_IDLE;
        end else if (letters_q != '0) begin
          state_d = S_EMIT;
        end else begin
          state_d = S_FIN;
        end
      end
      S_EMIT: begin
        if (out_free && !more) state_d = S_FIN;
      end
      S_FIN: begin
        if (in_q.char_code != CH_END || out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and result updates
  always_comb begin
    open_d      = open_q;
    pen_x_d     = pen_x_q;
    pen_y_d     = pen_y_q;
    ww_d        = ww_q;
    mlw_d       = mlw_q;
    letters_d   = letters_q;
    idx_d       = idx_q;
    pos_d       = pos_q;
    first_pos_d = first_pos_q;
    x_d         = x_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    ram_we      = 1'b0;
    ram_waddr   = letters_q[AW-1:0];
    ram_wdata   = '{adv: in_q.glyph_advance, bear: in_q.bearing_y, kern: in_q.kern_next};
    ram_re      = 1'b0;
    ram_raddr   = '0;

    case (state_q)
      // start of text loads the pen
      S_IDLE: begin
        if (accept && !open_q) begin
          open_d  = 1'b1;
          pen_x_d = left_pen;
          pen_y_d = sat_c(xw_t'(ascender_q) + xw_t'(pad_top_q));
        end
      end

      S_EXEC: begin
        if (is_letter) begin
          if (word_full) begin
            // dropped letter reported as truncated
            if (out_free) begin
              out_valid_d = 1'b1;
              out_d = '{kind: KIND_LETTER, char_index: pos_q, x_pos: '0, y_pos: '0,
                        status: ST_TRUNC, last: 1'b1};
              pos_d = pos_q + 16'd1;
            end
          end else begin
            // wrap test, then buffer the letter
            if (wrap) begin
              if (pen_x_q > mlw_q) mlw_d = pen_x_q;
              pen_x_d = left_pen;
              pen_y_d = sat_c(pen_line);
            end
            ww_d      = sat_c(ww_adv);
            ram_we    = 1'b1;
            letters_d = letters_q + LW'(1);
            if (letters_q == '0) first_pos_d = pos_q;
            pos_d     = pos_q + 16'd1;
          end
        end else if (letters_q != '0) begin
          // first read of the word flush
          ram_re    = 1'b1;
          ram_raddr = '0;
          idx_d     = '0;
          x_d       = xw_t'(pen_x_q);
        end
      end

      // one letter position per transaction
      S_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d = '{kind: KIND_LETTER, char_index: first_pos_q + 16'(idx_q),
                    x_pos: sat_o(sat_c(letter_x)), y_pos: sat_o(sat_c(letter_y)),
                    status: ST_OK, last: !more && (in_q.char_code != CH_END)};
          x_d   = x_q + xw_t'(ram_rdata.adv);
          idx_d = idx_nx;
          if (more) begin
            ram_re    = 1'b1;
            ram_raddr = idx_nx[AW-1:0];
          end
        end
      end

      // separator bookkeeping
      S_FIN: begin
        case (in_q.char_code)
          CH_END: begin
            if (out_free) begin
              out_valid_d = 1'b1;
              out_d = '{kind: KIND_SIZE, char_index: pos_q, x_pos: sat_o(size_w),
                        y_pos: sat_o(size_h), status: size_over ? ST_HEIGHT : ST_OK,
                        last: 1'b1};
              open_d    = 1'b0;
              pen_x_d   = '0;
              pen_y_d   = '0;
              ww_d      = '0;
              mlw_d     = '0;
              letters_d = '0;
              pos_d     = '0;
            end
          end
          CH_NEWLINE: begin
            if (letters_q != '0 && pen_end > mlw_q) mlw_d = pen_end;
            pen_x_d   = left_pen;
            pen_y_d   = sat_c(pen_line);
            ww_d      = '0;
            letters_d = '0;
            pos_d     = pos_q + 16'd1;
          end
          default: begin
            pen_x_d   = sat_c(pen_ww + xw_t'(in_q.glyph_advance));
            ww_d      = '0;
            letters_d = '0;
            pos_d     = pos_q + 16'd1;
          end
        endcase
      end

      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      open_q      <= 1'b0;
      pen_x_q     <= '0;
      pen_y_q     <= '0;
      ww_q        <= '0;
      mlw_q       <= '0;
      letters_q   <= '0;
      idx_q       <= '0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      open_q      <= open_d;
      pen_x_q     <= pen_x_d;
      pen_y_q     <= pen_y_d;
      ww_q        <= ww_d;
      mlw_q       <= mlw_d;
      letters_q   <= letters_d;
      idx_q       <= idx_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) in_q <= in_data_i;
    first_pos_q <= first_pos_d;
    x_q         <= x_d;
    out_q       <= out_d;
  end

endmodule

>>> sim/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import gwwl_pkg::*;

  localparam int     HOLD_CYCLES       = 8;
  localparam int     STUCK_LIMIT       = 5000;
  localparam int     ITEMS_PER_SETTING = 55;
  localparam int     LONG_TEXT_ITEMS   = 40;
  localparam longint UNBOUNDED         = 64'sd2147483647;

  typedef enum logic {
    ROW_CHAR,
    ROW_CFG
  } row_kind_e;

  // one row of the directed table
  typedef struct packed {
    row_kind_e             kind;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_val;
    in_item_t              c;
    logic [5:0]            rep;
    logic                  typed;
    out_item_t             want;
  } dir_row_t;

  logic                  clk      = 1'b0;
  logic                  rst_n    = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_item_t              in_data  = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_we   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx  = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int send_gap_pct   = 0;
  int recv_stall_pct = 0;
  int err_cnt        = 0;
  int stuck_cnt      = 0;

  // register copies
  longint pad_l, pad_r, pad_t, bound_w, bound_h, line_sp, asc_px, desc_px;

  // layout state
  longint      pen_x, pen_y, word_w, widest_line;
  int          n_letters;
  logic [15:0] text_pos;
  bit          text_open;
  word_ent_t   word_buf [WORD_MAX];
  logic [15:0] word_pos [WORD_MAX];

  out_item_t step_q  [$];
  out_item_t place_q [$];
  dir_row_t  dir_tab [$];

  greedy_word_wrap_layout_unit DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  always #10 clk = ~clk;

  // clamp to the signed coordinate range
  function automatic longint clip_coord(longint v);
    longint hi;
    longint lo;
    hi = (64'sd1 <<< (COORD_BITS - 1)) - 1;
    lo = -hi - 1;
    return (v > hi) ? hi : ((v < lo) ? lo : v);
  endfunction

  // clamp to the 16 bit result field
  function automatic longint clip_out(longint v);
    return (v > 32767) ? 64'sd32767 : ((v < -32768) ? -64'sd32768 : v);
  endfunction

  function automatic out_item_t mk_place(logic kind, logic [15:0] idx, longint x, longint y,
                                         logic [1:0] st);
    out_item_t r;
    longint    xs;
    longint    ys;
    xs = clip_out(x);
    ys = clip_out(y);
    r.kind       = kind;
    r.char_index = idx;
    r.x_pos      = xs[15:0];
    r.y_pos      = ys[15:0];
    r.status     = st;
    r.last       = 1'b0;
    return r;
  endfunction

  task automatic clear_text();
    pen_x       = 0;
    pen_y       = 0;
    word_w      = 0;
    widest_line = 0;
    n_letters   = 0;
    text_pos    = '0;
    text_open   = 1'b0;
  endtask

  // place every buffered letter at the pen
  task automatic place_word();
    longint x;
    x = pen_x;
    for (int i = 0; i < n_letters; i++) begin
      step_q.push_back(mk_place(KIND_LETTER, word_pos[i], x - longint'(word_buf[i].kern),
                                pen_y - longint'(word_buf[i].bear), ST_OK));
      x += longint'(word_buf[i].adv);
    end
    n_letters = 0;
  endtask

  // expected placements caused by one character
  task automatic lay_out_char(input in_item_t c);
    longint      adv;
    longint      max_w;
    longint      w;
    longint      h;
    longint      max_h;
    logic [15:0] pos;
    bit          had;
    out_item_t   tail;
    adv   = longint'(c.glyph_advance);
    pos   = text_pos;
    max_w = ((bound_w != 0) ? bound_w : UNBOUNDED) - pad_r;
    step_q.delete();
    // first character of a text loads the pen from the registers
    if (!text_open) begin
      pen_x     = clip_coord(pad_l);
      pen_y     = clip_coord(asc_px + pad_t);
      text_open = 1'b1;
    end
    if (c.char_code == CH_END) begin
      place_word();
      pen_x = clip_coord(pen_x + word_w);
      w     = (widest_line > pen_x) ? widest_line : pen_x;
      h     = clip_coord(pen_y - desc_px);
      max_h = (bound_h != 0) ? bound_h : UNBOUNDED;
      step_q.push_back(mk_place(KIND_SIZE, pos, w, h, (h > max_h) ? ST_HEIGHT : ST_OK));
      clear_text();
    end else if (c.char_code == CH_NEWLINE) begin
      had = (n_letters != 0);
      place_word();
      if (had) begin
        pen_x = clip_coord(pen_x + word_w);
        if (pen_x > widest_line) widest_line = pen_x;
      end
      pen_x  = clip_coord(pad_l);
      pen_y  = clip_coord(pen_y + line_sp);
      word_w = 0;
      text_pos++;
    end else if (c.char_code == CH_SPACE) begin
      place_word();
      pen_x  = clip_coord(pen_x + word_w + adv);
      word_w = 0;
      text_pos++;
    end else begin
      if (n_letters >= WORD_MAX) begin
        // buffer full: letter dropped and flagged
        step_q.push_back(mk_place(KIND_LETTER, pos, 0, 0, ST_TRUNC));
      end else begin
        // wrap before the letter joins the word
        if (pen_x + word_w + adv > max_w) begin
          if (pen_x > widest_line) widest_line = pen_x;
          pen_x = clip_coord(pad_l);
          pen_y = clip_coord(pen_y + line_sp);
        end
        word_w = clip_coord(word_w + adv);
        word_buf[n_letters].adv  = c.glyph_advance;
        word_buf[n_letters].bear = c.bearing_y;
        word_buf[n_letters].kern = c.kern_next;
        word_pos[n_letters]      = pos;
        n_letters++;
      end
      text_pos++;
    end
    if (step_q.size() > 0) begin
      tail      = step_q.pop_back();
      tail.last = 1'b1;
      step_q.push_back(tail);
    end
  endtask

  task automatic note_error(input string msg);
    err_cnt++;
    $display("mismatch: %s", msg);
  endtask

  // send one character transaction, then queue what it should cause
  task automatic push_char(input in_item_t c, input bit typed_on, input out_item_t typed);
    if ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_gap_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    lay_out_char(c);
    if (typed_on) place_q.push_back(typed);
    else foreach (step_q[j]) place_q.push_back(step_q[j]);
  endtask

  // register write, only with the block idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int v);
    logic signed [12:0] s13;
    int                 d;
    in_valid <= 1'b0;
    while (place_q.size() != 0) @(posedge clk);
    // a letter may still be in flight after the last result
    repeat (HOLD_CYCLES) @(posedge clk);
    d = ((idx == CFG_ASCENDER) || (idx == CFG_DESCENDER)) ? (v & 'h1fff) : (v & 'h7fff);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= d[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    s13 = d[12:0];
    case (idx)
      CFG_PAD_LEFT:     pad_l   = longint'(d & 'hfff);
      CFG_PAD_RIGHT:    pad_r   = longint'(d & 'hfff);
      CFG_PAD_TOP:      pad_t   = longint'(d & 'hfff);
      CFG_BOUND_WIDTH:  bound_w = longint'(d & 'h7fff);
      CFG_BOUND_HEIGHT: bound_h = longint'(d & 'h7fff);
      CFG_LINE_SPACE:   line_sp = longint'(d & 'hfff);
      CFG_ASCENDER:     asc_px  = longint'(s13);
      CFG_DESCENDER:    desc_px = longint'(s13);
      default: ;
    endcase
  endtask

  function automatic dir_row_t char_row(logic [7:0] code, logic [7:0] adv,
                                        logic signed [7:0] bear, logic signed [7:0] kern,
                                        int rep);
    dir_row_t r;
    r = '0;
    r.kind            = ROW_CHAR;
    r.c.char_code     = code;
    r.c.glyph_advance = adv;
    r.c.bearing_y     = bear;
    r.c.kern_next     = kern;
    r.rep             = 6'(rep);
    return r;
  endfunction

  function automatic dir_row_t typed_row(logic [7:0] code, logic [7:0] adv,
                                         logic signed [7:0] bear, logic signed [7:0] kern,
                                         logic kind, logic [15:0] idx, longint x, longint y,
                                         logic [1:0] st);
    dir_row_t r;
    r = char_row(code, adv, bear, kern, 1);
    r.typed     = 1'b1;
    r.want      = mk_place(kind, idx, x, y, st);
    r.want.last = 1'b1;
    return r;
  endfunction

  function automatic dir_row_t cfg_row(logic [CFG_IDX_W-1:0] idx, int v);
    dir_row_t r;
    r = '0;
    r.kind    = ROW_CFG;
    r.cfg_idx = idx;
    r.cfg_val = v[CFG_DATA_W-1:0];
    return r;
  endfunction

  function automatic in_item_t rand_letter();
    in_item_t c;
    c.char_code = 8'($urandom_range(255, 1));
    if ((c.char_code == CH_NEWLINE) || (c.char_code == CH_SPACE)) c.char_code = 8'd65;
    c.glyph_advance = ($urandom_range(7) == 0) ? 8'($urandom_range(255))
                                               : 8'($urandom_range(40));
    c.bearing_y = 8'($urandom);
    c.kern_next = 8'($urandom);
    return c;
  endfunction

  // receiver stall
  always @(posedge clk) out_stall <= ($urandom_range(99) < recv_stall_pct);

  // compare each result transaction with the oldest expectation
  always @(posedge clk) begin : result_check
    out_item_t exp_r;
    out_item_t got;
    if (rst_n && out_valid && !out_stall) begin
      got = out_data;
      if (place_q.size() == 0) begin
        note_error($sformatf("unexpected result at index %0d", got.char_index));
      end else begin
        exp_r = place_q.pop_front();
        if (got.kind !== exp_r.kind)
          note_error($sformatf("kind at index %0d: got %0d, want %0d",
                               exp_r.char_index, got.kind, exp_r.kind));
        if (got.char_index !== exp_r.char_index)
          note_error($sformatf("char_index: got %0d, want %0d",
                               got.char_index, exp_r.char_index));
        if (got.x_pos !== exp_r.x_pos)
          note_error($sformatf("x_pos at index %0d: got %0d, want %0d",
                               exp_r.char_index, got.x_pos, exp_r.x_pos));
        if (got.y_pos !== exp_r.y_pos)
          note_error($sformatf("y_pos at index %0d: got %0d, want %0d",
                               exp_r.char_index, got.y_pos, exp_r.y_pos));
        if (got.status !== exp_r.status)
          note_error($sformatf("status at index %0d: got %0d, want %0d",
                               exp_r.char_index, got.status, exp_r.status));
        if (got.last !== exp_r.last)
          note_error($sformatf("last at index %0d: got %0d, want %0d",
                               exp_r.char_index, got.last, exp_r.last));
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) stuck_cnt = 0;
      else stuck_cnt++;
      if (stuck_cnt >= STUCK_LIMIT) begin
        $display("greedy_word_wrap_layout_unit verification failed");
        $finish;
      end
    end
  end

  initial begin
    int                   n;
    int                   len;
    int                   sep;
    int                   v;
    in_item_t             c;
    int                   set_tab [6][8];
    logic [CFG_IDX_W-1:0] reg_order [8];

    reg_order = '{CFG_PAD_LEFT, CFG_PAD_RIGHT, CFG_PAD_TOP, CFG_BOUND_WIDTH,
                  CFG_BOUND_HEIGHT, CFG_LINE_SPACE, CFG_ASCENDER, CFG_DESCENDER};
    // register settings in reg_order; the fourth one is drawn at random
    set_tab = '{'{8, 4, 2, 200, 120, 14, 10, -3},
                '{4095, 4095, 4095, 32767, 32767, 4095, 4095, 4095},
                '{0, 0, 0, 0, 0, 0, -4096, -4096},
                '{0, 0, 0, 0, 0, 0, 0, 0},
                '{0, 0, 0, 1, 1, 1, -1, 1},
                '{0, 0, 0, 0, 0, 16, 12, -4}};

    // reset view of registers and text
    pad_l   = 0;
    pad_r   = 0;
    pad_t   = 0;
    bound_w = 0;
    bound_h = 0;
    line_sp = 16;
    asc_px  = 12;
    desc_px = -4;
    clear_text();

    // end code right after reset: empty text, pen from reset registers
    dir_tab.push_back(typed_row(CH_END, 8'd0, 8'sd0, 8'sd0,
                                KIND_SIZE, 16'd0, 0, 16, ST_OK));
    // letter field extremes
    dir_tab.push_back(char_row(8'd65, 8'd255, 8'sd127, 8'sd127, 1));
    dir_tab.push_back(char_row(8'd122, 8'd0, 8'sh80, 8'sh80, 1));
    dir_tab.push_back(char_row(CH_SPACE, 8'd255, 8'sd0, 8'sd0, 1));
    dir_tab.push_back(char_row(8'd255, 8'd10, 8'sd0, 8'sd0, 1));
    dir_tab.push_back(char_row(CH_NEWLINE, 8'd0, 8'sd0, 8'sd0, 1));
    // newline with no word
    dir_tab.push_back(char_row(CH_NEWLINE, 8'd3, -8'sd1, 8'sd1, 1));
    // zero-width word is still placed
    dir_tab.push_back(char_row(8'd1, 8'd0, 8'sd5, -8'sd5, 1));
    dir_tab.push_back(char_row(8'd9, 8'd0, -8'sd7, 8'sd7, 1));
    dir_tab.push_back(char_row(CH_SPACE, 8'd0, 8'sd0, 8'sd0, 1));
    dir_tab.push_back(char_row(CH_SPACE, 8'd17, 8'sd0, 8'sd0, 1));
    // fill the word buffer, then two letters past it are dropped
    dir_tab.push_back(char_row(8'd33, 8'd5, 8'sd3, -8'sd2, WORD_MAX));
    dir_tab.push_back(typed_row(8'd200, 8'd7, 8'sd5, 8'sd5,
                                KIND_LETTER, 16'd42, 0, 0, ST_TRUNC));
    dir_tab.push_back(typed_row(8'd201, 8'd9, -8'sd5, -8'sd5,
                                KIND_LETTER, 16'd43, 0, 0, ST_TRUNC));
    // full word flush plus size
    dir_tab.push_back(char_row(CH_END, 8'd0, 8'sd0, 8'sd0, 1));
    // narrow bound: second letter wraps, text taller than the bound
    dir_tab.push_back(cfg_row(CFG_PAD_LEFT, 100));
    dir_tab.push_back(cfg_row(CFG_BOUND_WIDTH, 140));
    dir_tab.push_back(cfg_row(CFG_BOUND_HEIGHT, 20));
    dir_tab.push_back(char_row(8'd97, 8'd30, 8'sd9, 8'sd1, 1));
    dir_tab.push_back(char_row(8'd98, 8'd30, 8'sd9, -8'sd1, 1));
    dir_tab.push_back(char_row(CH_END, 8'd0, 8'sd0, 8'sd0, 1));
    // new text loads the pen from the updated padding
    dir_tab.push_back(typed_row(CH_END, 8'd0, 8'sd0, 8'sd0,
                                KIND_SIZE, 16'd0, 100, 16, ST_OK));
    dir_tab.push_back(cfg_row(CFG_BOUND_HEIGHT, 15));
    dir_tab.push_back(typed_row(CH_END, 8'd0, 8'sd0, 8'sd0,
                                KIND_SIZE, 16'd0, 100, 16, ST_HEIGHT));

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed table
    send_gap_pct   = 26;
    recv_stall_pct = 61;
    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_CFG) begin
        write_reg(dir_tab[i].cfg_idx, int'(dir_tab[i].cfg_val));
      end else begin
        for (int k = 0; k < int'(dir_tab[i].rep); k++)
          push_char(dir_tab[i].c, dir_tab[i].typed, dir_tab[i].want);
      end
    end

    // random texts, one register setting each; writes drain the block first
    for (int s = 0; s < 6; s++) begin
      if (s < 2) begin
        send_gap_pct   = 26;
        recv_stall_pct = 61;
      end else if (s < 4) begin
        send_gap_pct   = 61;
        recv_stall_pct = 26;
      end else begin
        send_gap_pct   = 0;
        recv_stall_pct = 0;
      end
      for (int r = 0; r < 8; r++) begin
        v = set_tab[s][r];
        if (s == 3) begin
          case (reg_order[r])
            CFG_BOUND_WIDTH:             v = $urandom_range(800, 40);
            CFG_BOUND_HEIGHT:            v = $urandom_range(32767);
            CFG_ASCENDER, CFG_DESCENDER: v = int'($urandom_range(8191)) - 4096;
            default:                     v = $urandom_range(4095);
          endcase
        end
        write_reg(reg_order[r], v);
      end
      n = 0;
      while (n < ITEMS_PER_SETTING) begin
        if ($urandom_range(99) < 15) begin
          // noise: any code, any fields
          c = in_item_t'($urandom);
          push_char(c, 1'b0, '0);
          n++;
        end else begin
          // one word, sometimes past the buffer size, then a separator
          len = ($urandom_range(11) == 0) ? $urandom_range(36, 30) : $urandom_range(6, 1);
          for (int k = 0; k < len; k++) begin
            push_char(rand_letter(), 1'b0, '0);
            n++;
          end
          sep = $urandom_range(99);
          c = rand_letter();
          c.char_code = (sep < 60) ? CH_SPACE : ((sep < 85) ? CH_NEWLINE : CH_END);
          push_char(c, 1'b0, '0);
          n++;
        end
      end
      c = rand_letter();
      c.char_code = CH_END;
      push_char(c, 1'b0, '0);
    end

    // one text of mostly spaces with an odd newline or letter
    for (int k = 0; k < LONG_TEXT_ITEMS; k++) begin
      sep = $urandom_range(255);
      c = rand_letter();
      if (sep == 1) c.char_code = CH_NEWLINE;
      else if (sep > 1) c.char_code = CH_SPACE;
      push_char(c, 1'b0, '0);
    end
    c = rand_letter();
    c.char_code = CH_END;
    push_char(c, 1'b0, '0);

    // drain and let the block settle
    in_valid <= 1'b0;
    while (place_q.size() != 0) @(posedge clk);
    repeat (2 * HOLD_CYCLES) @(posedge clk);

    if (err_cnt == 0) begin
      $display("greedy_word_wrap_layout_unit verification clean");
    end else begin
      $display("greedy_word_wrap_layout_unit verification failed");
    end
    $finish;
  end

endmodule
